>>> rtl/lzcw_pkg.sv
// shared types and constants of the lz control word decompressor
package lzcw_pkg;

	// register indexes of the configuration port
	localparam logic REG_OUTPUT_SIZE  = 1'b0;
	localparam logic REG_INPUT_LENGTH = 1'b1;

	// end status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BAD   = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	// result buffer: at most 272 bytes per item, packed eight to an entry
	localparam int          STEP_BYTES = 272;
	localparam int          RBUF_DEPTH = 34;
	localparam int          RBUF_AW    = 6;
	localparam logic [31:0] SENTINEL   = 32'd1;
	localparam logic [31:0] TAIL_CTRL  = 32'h8000_0000;

	// control from the decoder to the result packer
	typedef struct packed {
		logic       start;
		logic       push;
		logic [7:0] push_byte;
		logic       finish;
		logic       job_done;
		logic [1:0] status;
	} res_ctl_t;

	// literal run length from the low four control bits
	function automatic logic [2:0] lit_run(input logic [3:0] c);
		logic [2:0] n;
		case (c)
			4'd0:    n = 3'd4;
			4'd2:    n = 3'd1;
			4'd4:    n = 3'd2;
			4'd6:    n = 3'd1;
			4'd8:    n = 3'd3;
			4'd10:   n = 3'd1;
			4'd12:   n = 3'd2;
			4'd14:   n = 3'd1;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

>>> rtl/lzcw_if.sv
// valid/ready channels for compressed input and packed output items
interface lzcw_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface lzcw_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_bytes;
	logic [3:0]  out_count;
	logic        run_last;
	logic        job_done;
	logic [1:0]  status;
	modport source (output valid, output out_bytes, output out_count, output run_last,
		output job_done, output status, input ready);
	modport sink (input valid, input out_bytes, input out_count, input run_last,
		input job_done, input status, output ready);
endinterface

>>> rtl/lz_control_word_decompressor.sv
// top level: control word decoder, lookahead, history copy and result playout
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      in_byte
//  out_ch    out  valid/ready      out_bytes, out_count, run_last, job_done, status
//  cfg       in   cfg_we           cfg_index, cfg_wdata
//
// an item enters in S_IDLE and is decoded in S_ADV steps; literals go out in S_LIT,
// each byte copied from history is read then written back (S_MRD, S_MWR), and
// each result item is read from the entry store and then played out.
// after reset a zeroing sweep of the history memory runs before the first item.
// a stalled output holds the last result; the next item may enter meanwhile.
module lz_control_word_decompressor #(
	parameter int HISTORY_DEPTH   = 131072,
	parameter int MAX_OUTPUT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_wdata,
	lzcw_in_if.sink     in_ch,
	lzcw_out_if.source  out_ch
);
	import lzcw_pkg::*;

	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int MOB = MAX_OUTPUT_BITS;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_ADV   = 7'b0000100,
		S_LIT   = 7'b0001000,
		S_MRD   = 7'b0010000,
		S_MWR   = 7'b0100000,
		S_WAIT  = 7'b1000000
	} state_t;

	state_t          state_q, state_d;
	logic [23:0]     osize_q, ilen_q;
	logic [31:0]     ctrl_q, ctrl_d;
	logic [7:0]      la_q [4];
	logic [7:0]      la_d [4];
	logic [2:0]      fill_q, fill_d;
	logic [23:0]     in_pos_q, in_pos_d;
	logic [MOB-1:0]  out_pos_q, out_pos_d;
	logic [AW-1:0]   wr_q, wr_d;
	logic            tail_q, tail_d;
	logic            done_q, done_d;
	logic [1:0]      status_q, status_d;
	logic [8:0]      rem_q, rem_d;
	logic [16:0]     off_q, off_d;

	logic [31:0]     peek;
	logic [32:0]     op33, size33;
	logic            in_need4, in_empty, near_end, out_full;
	logic [16:0]     m_off;
	logic [8:0]      m_len;
	logic [2:0]      m_used;
	logic            m_bad;
	logic [2:0]      drop_n, dn;
	logic            put_en;
	logic [7:0]      put_b;
	logic            stop;
	logic            hist_re;
	logic [AW-1:0]   rd_addr;
	logic [AW:0]     rd_diff;
	logic [7:0]      hist_rdata;
	logic            hist_clearing;
	logic            res_busy;
	res_ctl_t        ctl;
	logic            accept;

	assign peek     = {la_q[3], la_q[2], la_q[1], la_q[0]};
	assign op33     = 33'(out_pos_q);
	assign size33   = 33'(osize_q);
	assign in_need4 = (25'(in_pos_q) + 25'd4) > 25'(ilen_q);
	assign in_empty = in_pos_q >= ilen_q;
	assign near_end = (op33 + 33'd10) >= size33;
	assign out_full = op33 >= size33;
	assign accept   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	// match format decode
	always_comb begin
		if (peek[1:0] == 2'b00) begin
			m_off  = 17'(peek[7:2]);
			m_len  = 9'd3;
			m_used = 3'd1;
		end else if (!peek[1]) begin
			m_off  = 17'(peek[15:2]);
			m_len  = 9'd3;
			m_used = 3'd2;
		end else if (!peek[0]) begin
			m_off  = 17'(peek[15:6]);
			m_len  = 9'(peek[5:2]) + 9'd3;
			m_used = 3'd2;
		end else if (peek[6:0] == 7'h03) begin
			m_off  = peek[31:15];
			m_len  = 9'(peek[14:7]) + 9'd3;
			m_used = 3'd4;
		end else begin
			m_off  = peek[23:7];
			m_len  = 9'(peek[6:2]) + 9'd2;
			m_used = 3'd3;
		end
	end
	assign m_bad = (33'(m_off) > op33) || ((op33 + 33'(m_len)) > size33);

	// source address of a history copy, wrapped into the memory
	assign rd_diff = (AW + 1)'(wr_q) - (AW + 1)'(off_q);
	assign rd_addr = (wr_q >= AW'(off_q)) ? rd_diff[AW-1:0]
		: AW'(rd_diff + (AW + 1)'(HISTORY_DEPTH));

	// decoder step
	always_comb begin
		state_d  = state_q;
		ctrl_d   = ctrl_q;
		la_d     = la_q;
		fill_d   = fill_q;
		in_pos_d = in_pos_q;
		out_pos_d = out_pos_q;
		wr_d     = wr_q;
		tail_d   = tail_q;
		done_d   = done_q;
		status_d = status_q;
		rem_d    = rem_q;
		off_d    = off_q;
		drop_n   = 3'd0;
		put_en   = 1'b0;
		put_b    = 8'h00;
		stop     = 1'b0;
		hist_re  = 1'b0;
		ctl      = '0;
		case (state_q)
			S_CLEAR: begin
				if (!hist_clearing) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					ctl.start = 1'b1;
					if (!done_q && fill_q != 3'd4 &&
						(25'(in_pos_q) + 25'(fill_q)) < 25'(ilen_q)) begin
						la_d[fill_q[1:0]] = in_ch.in_byte;
						fill_d = fill_q + 1'b1;
					end
					state_d = S_ADV;
				end
			end
			S_ADV: begin
				if (done_q) begin
					stop = 1'b1;
				end else if (out_full) begin
					done_d   = 1'b1;
					status_d = ST_OK;
					stop     = 1'b1;
				end else if (!tail_q) begin
					if (in_need4) begin
						tail_d = 1'b1;
					end else if (fill_q != 3'd4) begin
						stop = 1'b1;
					end else if (ctrl_q == SENTINEL) begin
						ctrl_d = peek;
						drop_n = 3'd4;
					end else if (!ctrl_q[0]) begin
						if (near_end) begin
							tail_d = 1'b1;
						end else begin
							rem_d   = 9'(lit_run(ctrl_q[3:0]));
							state_d = S_LIT;
						end
					end else begin
						drop_n = m_used;
						if (m_bad) begin
							done_d   = 1'b1;
							status_d = ST_BAD;
							stop     = 1'b1;
						end else begin
							ctrl_d  = ctrl_q >> 1;
							off_d   = m_off;
							rem_d   = m_len;
							state_d = S_MRD;
						end
					end
				end else begin
					if (ctrl_q == SENTINEL) begin
						if (in_need4) begin
							done_d   = 1'b1;
							status_d = ST_SHORT;
							stop     = 1'b1;
						end else if (fill_q != 3'd4) begin
							stop = 1'b1;
						end else begin
							ctrl_d = TAIL_CTRL;
							drop_n = 3'd4;
						end
					end else if (in_empty) begin
						done_d   = 1'b1;
						status_d = ST_SHORT;
						stop     = 1'b1;
					end else if (fill_q == 3'd0) begin
						stop = 1'b1;
					end else begin
						put_en = 1'b1;
						put_b  = la_q[0];
						drop_n = 3'd1;
						ctrl_d = ctrl_q >> 1;
					end
				end
				if (stop) begin
					ctl.finish   = 1'b1;
					ctl.job_done = done_d;
					ctl.status   = status_d;
					state_d      = S_WAIT;
				end
			end
			S_LIT: begin
				put_en = 1'b1;
				put_b  = la_q[0];
				drop_n = 3'd1;
				ctrl_d = ctrl_q >> 1;
				rem_d  = rem_q - 1'b1;
				if (rem_q == 9'd1) state_d = S_ADV;
			end
			S_MRD: begin
				if (off_q == 17'd0) begin
					put_en = 1'b1;
					rem_d  = rem_q - 1'b1;
					if (rem_q == 9'd1) state_d = S_ADV;
				end else begin
					hist_re = 1'b1;
					state_d = S_MWR;
				end
			end
			S_MWR: begin
				put_en  = 1'b1;
				put_b   = hist_rdata;
				rem_d   = rem_q - 1'b1;
				state_d = (rem_q == 9'd1) ? S_ADV : S_MRD;
			end
			S_WAIT: begin
				if (!res_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase

		// consume lookahead bytes
		dn = (drop_n > fill_q) ? fill_q : drop_n;
		if (drop_n != 3'd0) begin
			for (int i = 0; i < 4; i++) begin
				la_d[i] = ((3'(i) + dn) < 3'd4) ? la_q[2'(3'(i) + dn)] : 8'h00;
			end
			fill_d   = fill_q - dn;
			in_pos_d = in_pos_q + 24'(dn);
		end

		// one output byte into history and the packer
		if (put_en) begin
			out_pos_d     = out_pos_q + 1'b1;
			wr_d          = (out_pos_d == '0 || wr_q == AW'(HISTORY_DEPTH - 1)) ? '0
				: wr_q + 1'b1;
			ctl.push      = 1'b1;
			ctl.push_byte = put_b;
		end

		// a register write restarts the job
		if (cfg_we) begin
			ctrl_d    = SENTINEL;
			for (int i = 0; i < 4; i++) la_d[i] = 8'h00;
			fill_d    = 3'd0;
			in_pos_d  = '0;
			out_pos_d = '0;
			wr_d      = '0;
			tail_d    = 1'b0;
			done_d    = 1'b0;
			status_d  = ST_OK;
		end
	end

	// job and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			osize_q   <= 24'd11;
			ilen_q    <= 24'd0;
			ctrl_q    <= SENTINEL;
			for (int i = 0; i < 4; i++) la_q[i] <= 8'h00;
			fill_q    <= 3'd0;
			in_pos_q  <= '0;
			out_pos_q <= '0;
			wr_q      <= '0;
			tail_q    <= 1'b0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			rem_q     <= '0;
			off_q     <= '0;
		end else begin
			state_q   <= state_d;
			ctrl_q    <= ctrl_d;
			la_q      <= la_d;
			fill_q    <= fill_d;
			in_pos_q  <= in_pos_d;
			out_pos_q <= out_pos_d;
			wr_q      <= wr_d;
			tail_q    <= tail_d;
			done_q    <= done_d;
			status_q  <= status_d;
			rem_q     <= rem_d;
			off_q     <= off_d;
			if (cfg_we) begin
				if (cfg_index == REG_OUTPUT_SIZE) osize_q <= cfg_wdata;
				else ilen_q <= cfg_wdata;
			end
		end
	end

	lzcw_hist #(
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (put_en),
		.waddr    (wr_q),
		.wdata    (put_b),
		.re       (hist_re),
		.raddr    (rd_addr),
		.rdata    (hist_rdata),
		.clearing (hist_clearing)
	);

	lzcw_result u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.busy   (res_busy),
		.out_ch (out_ch)
	);

`ifndef SYNTHESIS
	a_no_item_during_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !hist_clearing) else $error("item taken during history sweep");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'd4) else $error("lookahead overfilled");
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MWR |-> $past(state_q == S_MRD)) else $error("copy write without read");
	a_lit_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LIT |-> fill_q != 3'd0) else $error("literal with empty lookahead");
`endif

endmodule

>>> rtl/lzcw_hist.sv
// output history memory with a zeroing sweep after reset
module lzcw_hist #(
	parameter int DEPTH = 131072
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata,
	output logic                     clearing
);
	localparam int AW = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          clearing_q;

	// sweep pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(DEPTH - 1)) clearing_q <= 1'b0;
		end
	end

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (clearing_q) mem[clr_q] <= 8'h00;
		else if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

	assign clearing = clearing_q;

endmodule

>>> rtl/lzcw_result.sv
// packs output bytes eight to an entry and plays the entries out as items
module lzcw_result (
	input  logic              clk,
	input  logic              arst_n,
	input  lzcw_pkg::res_ctl_t ctl,
	output logic              busy,
	lzcw_out_if.source        out_ch
);
	import lzcw_pkg::*;

	typedef enum logic [2:0] {
		R_IDLE = 3'b001,
		R_RD   = 3'b010,
		R_OUT  = 3'b100
	} rstate_t;

	rstate_t             state_q;
	logic [67:0]         rbuf [RBUF_DEPTH];
	logic [67:0]         rdata_q;
	logic [63:0]         chunk_q;
	logic [3:0]          ccnt_q;
	logic [8:0]          scnt_q;
	logic [RBUF_AW-1:0]  nwr_q;
	logic [RBUF_AW-1:0]  ri_q;
	logic                fin_done_q;
	logic [1:0]          fin_st_q;
	logic                ov_q;
	logic [63:0]         ob_q;
	logic [3:0]          oc_q;
	logic                ol_q;
	logic                od_q;
	logic [1:0]          os_q;
	logic                full;
	logic                push_ok;
	logic                buf_we;
	logic                load;

	assign full    = (ccnt_q == 4'd8);
	assign push_ok = ctl.push && (scnt_q < 9'(STEP_BYTES));
	assign buf_we  = (push_ok && full) || ctl.finish;
	assign load    = (state_q == R_OUT) && (!ov_q || out_ch.ready);

	// entry store
	always_ff @(posedge clk) begin
		if (buf_we) rbuf[nwr_q] <= {ccnt_q, chunk_q};
		if (state_q == R_RD) rdata_q <= rbuf[ri_q];
	end

	// byte packing and playout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			ccnt_q  <= '0;
			scnt_q  <= '0;
			nwr_q   <= '0;
			ri_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ctl.start) begin
				ccnt_q <= '0;
				scnt_q <= '0;
				nwr_q  <= '0;
			end else if (push_ok) begin
				scnt_q <= scnt_q + 1'b1;
				if (full) begin
					nwr_q  <= nwr_q + 1'b1;
					ccnt_q <= 4'd1;
				end else begin
					ccnt_q <= ccnt_q + 1'b1;
				end
			end
			if (load) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
			case (state_q)
				R_IDLE: begin
					if (ctl.finish) begin
						ri_q    <= '0;
						state_q <= R_RD;
					end
				end
				R_RD: state_q <= R_OUT;
				R_OUT: begin
					if (load) begin
						if (ri_q == nwr_q) begin
							state_q <= R_IDLE;
						end else begin
							ri_q    <= ri_q + 1'b1;
							state_q <= R_RD;
						end
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			chunk_q <= '0;
		end else if (push_ok) begin
			if (full) chunk_q <= {56'd0, ctl.push_byte};
			else chunk_q[ccnt_q[2:0]*8 +: 8] <= ctl.push_byte;
		end
		if (ctl.finish) begin
			fin_done_q <= ctl.job_done;
			fin_st_q   <= ctl.status;
		end
		if (load) begin
			ob_q <= rdata_q[63:0];
			oc_q <= rdata_q[67:64];
			ol_q <= (ri_q == nwr_q);
			od_q <= fin_done_q;
			os_q <= fin_st_q;
		end
	end

	assign busy             = (state_q != R_IDLE);
	assign out_ch.valid     = ov_q;
	assign out_ch.out_bytes = ob_q;
	assign out_ch.out_count = oc_q;
	assign out_ch.run_last  = ol_q;
	assign out_ch.job_done  = od_q;
	assign out_ch.status    = os_q;

endmodule
